// ===== rtl/ecs_pkg.sv =====
// shared types, codepoint constants and class decoders of the emoji cluster segmenter
package ecs_pkg;

    localparam int CP_W        = 21;
    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    localparam logic [CP_W-1:0] CP_ZERO   = 21'h000000;
    localparam logic [CP_W-1:0] CP_VS16   = 21'h00FE0F;
    localparam logic [CP_W-1:0] CP_ZWJ    = 21'h00200D;
    localparam logic [CP_W-1:0] CP_KEYCAP = 21'h0020E3;

    typedef enum logic [1:0] {
        KIND_PLAIN  = 2'd0,
        KIND_KEYCAP = 2'd1,
        KIND_FLAG   = 2'd2,
        KIND_PICT   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [CP_W-1:0] codepoint;
        logic            end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0] codepoint;
        kind_t           kind;
        logic            start;
    } result_t;

    typedef result_t [MAX_RESULTS-1:0] res_vec_t;

    typedef struct packed {
        res_vec_t         slots;
        logic [CNT_W-1:0] count;
    } parse_res_t;

    function automatic logic in_range(input logic [CP_W-1:0] c,
                                      input logic [CP_W-1:0] lo,
                                      input logic [CP_W-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic is_pict(input logic [CP_W-1:0] c);
        return in_range(c, 21'h002600, 21'h0027BF) || in_range(c, 21'h002300, 21'h0023FF) ||
               in_range(c, 21'h002B00, 21'h002BFF) || in_range(c, 21'h002190, 21'h0021FF) ||
               in_range(c, 21'h01F300, 21'h01FAFF);
    endfunction

    function automatic logic is_ri(input logic [CP_W-1:0] c);
        return in_range(c, 21'h01F1E6, 21'h01F1FF);
    endfunction

    function automatic logic is_skin(input logic [CP_W-1:0] c);
        return in_range(c, 21'h01F3FB, 21'h01F3FF);
    endfunction

    function automatic logic is_key_base(input logic [CP_W-1:0] c);
        return in_range(c, 21'h000030, 21'h000039) || (c == 21'h000023) || (c == 21'h00002A);
    endfunction

endpackage

// ===== rtl/ecs_in_if.sv =====
// input channel: one codepoint request with its end-of-text mark
interface ecs_in_if;
    logic                     valid;
    logic                     ready;
    logic [ecs_pkg::CP_W-1:0] codepoint;
    logic                     end_of_text;

    modport source (output valid, codepoint, end_of_text, input ready);
    modport sink   (input valid, codepoint, end_of_text, output ready);
endinterface

// ===== rtl/ecs_out_if.sv =====
// output channel: one tagged codepoint per handshake
interface ecs_out_if;
    logic                     valid;
    logic                     ready;
    logic [ecs_pkg::CP_W-1:0] out_codepoint;
    logic [1:0]               cluster_kind;
    logic                     starts_cluster;
    logic                     last;

    modport source (output valid, out_codepoint, cluster_kind, starts_cluster, last,
                    input ready);
    modport sink   (input valid, out_codepoint, cluster_kind, starts_cluster, last,
                    output ready);
endinterface

// ===== rtl/emoji_cluster_segmenter_core.sv =====
// top level of the emoji cluster segmenter
// Takes one codepoint request per cycle while the output buffer has room and releases
// every codepoint in its original order, tagged with a cluster kind (plain, keycap, flag,
// pictographic) and a start-of-cluster flag; last marks the final result caused by one
// input request. A request passes an input register and then a result register before
// its first result appears. A request yields zero to three results, and the output port
// delivers one result per cycle while ready is high, so throughput is one request per
// cycle while each yields at most one result; a request yielding several results occupies
// the output until all are delivered. Keycap bases, a first regional indicator and a
// trailing joiner are held inside until the next codepoint or end-of-text mark decides them.
module emoji_cluster_segmenter_core (
    input  logic       clk,
    input  logic       rst_n,
    ecs_in_if.sink     in_ch,
    ecs_out_if.source  out_ch
);

    ecs_pkg::in_item_t   item;
    ecs_pkg::parse_res_t res;
    logic                adv;
    logic                free;

    ecs_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .free  (free),
        .item  (item),
        .adv   (adv)
    );

    ecs_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .item  (item),
        .res   (res)
    );

    ecs_out_buf u_out_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (adv),
        .res    (res),
        .free   (free),
        .out_ch (out_ch)
    );

endmodule

// ===== rtl/ecs_in_stage.sv =====
// input register: captures one codepoint request and hands it to the parser
module ecs_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    ecs_in_if.sink            in_ch,
    input  logic              free,
    output ecs_pkg::in_item_t item,
    output logic              adv
);

    logic              valid_reg;
    logic              valid_next;
    ecs_pkg::in_item_t item_reg;

    assign adv         = valid_reg && free;
    assign in_ch.ready = !valid_reg || free;
    assign item        = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ch.valid && in_ch.ready)
        begin
            valid_next = 1'b1;
        end
        else if (adv)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.codepoint   <= in_ch.codepoint;
            item_reg.end_of_text <= in_ch.end_of_text;
        end
    end

endmodule

// ===== rtl/ecs_parser.sv =====
// cluster parser: mode and held codepoint, decodes one codepoint into up to three results
module ecs_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  ecs_pkg::in_item_t   item,
    output ecs_pkg::parse_res_t res
);

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_KEY_BASE  = 3'd1,
        MODE_KEY_VS    = 3'd2,
        MODE_RI        = 3'd3,
        MODE_PICT_BASE = 3'd4,
        MODE_PICT_VS   = 3'd5,
        MODE_PICT_SKIN = 3'd6,
        MODE_PICT_ZWJ  = 3'd7
    } mode_t;

    mode_t                       mode_reg;
    mode_t                       mode_next;
    logic [ecs_pkg::CP_W-1:0]    held_reg;
    logic [ecs_pkg::CP_W-1:0]    held_next;
    ecs_pkg::res_vec_t           slots;
    logic [ecs_pkg::CNT_W-1:0]   n;
    logic                        do_fresh;
    logic [ecs_pkg::CP_W-1:0]    cp;

    function automatic void push(inout ecs_pkg::res_vec_t v,
                                 inout logic [ecs_pkg::CNT_W-1:0] cnt,
                                 input logic [ecs_pkg::CP_W-1:0] c,
                                 input ecs_pkg::kind_t k,
                                 input logic s);
        if (cnt != ecs_pkg::CNT_W'(ecs_pkg::MAX_RESULTS))
        begin
            v[cnt[ecs_pkg::IDX_W-1:0]].codepoint = c;
            v[cnt[ecs_pkg::IDX_W-1:0]].kind      = k;
            v[cnt[ecs_pkg::IDX_W-1:0]].start     = s;
            cnt = cnt + ecs_pkg::CNT_W'(1);
        end
    endfunction

    assign cp = item.codepoint;

    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        slots     = '0;
        n         = '0;
        do_fresh  = 1'b0;

        unique case (mode_reg)
            MODE_KEY_BASE:
            begin
                if (cp == ecs_pkg::CP_VS16)
                begin
                    mode_next = MODE_KEY_VS;
                end
                else if (cp == ecs_pkg::CP_KEYCAP)
                begin
                    push(slots, n, held_reg, ecs_pkg::KIND_KEYCAP, 1'b1);
                    push(slots, n, cp, ecs_pkg::KIND_KEYCAP, 1'b0);
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    push(slots, n, held_reg, ecs_pkg::KIND_PLAIN, 1'b1);
                    do_fresh = 1'b1;
                end
            end
            MODE_KEY_VS:
            begin
                if (cp == ecs_pkg::CP_KEYCAP)
                begin
                    push(slots, n, held_reg, ecs_pkg::KIND_KEYCAP, 1'b1);
                    push(slots, n, ecs_pkg::CP_VS16, ecs_pkg::KIND_KEYCAP, 1'b0);
                    push(slots, n, cp, ecs_pkg::KIND_KEYCAP, 1'b0);
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    push(slots, n, held_reg, ecs_pkg::KIND_PLAIN, 1'b1);
                    push(slots, n, ecs_pkg::CP_VS16, ecs_pkg::KIND_PLAIN, 1'b1);
                    do_fresh = 1'b1;
                end
            end
            MODE_RI:
            begin
                if (ecs_pkg::is_ri(cp))
                begin
                    push(slots, n, held_reg, ecs_pkg::KIND_FLAG, 1'b1);
                    push(slots, n, cp, ecs_pkg::KIND_FLAG, 1'b0);
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    push(slots, n, held_reg, ecs_pkg::KIND_PLAIN, 1'b1);
                    do_fresh = 1'b1;
                end
            end
            MODE_PICT_BASE:
            begin
                if (cp == ecs_pkg::CP_VS16)
                begin
                    push(slots, n, cp, ecs_pkg::KIND_PICT, 1'b0);
                    mode_next = MODE_PICT_VS;
                end
                else if (ecs_pkg::is_skin(cp))
                begin
                    push(slots, n, cp, ecs_pkg::KIND_PICT, 1'b0);
                    mode_next = MODE_PICT_SKIN;
                end
                else if (cp == ecs_pkg::CP_ZWJ)
                begin
                    held_next = cp;
                    mode_next = MODE_PICT_ZWJ;
                end
                else
                begin
                    do_fresh = 1'b1;
                end
            end
            MODE_PICT_VS:
            begin
                if (ecs_pkg::is_skin(cp))
                begin
                    push(slots, n, cp, ecs_pkg::KIND_PICT, 1'b0);
                    mode_next = MODE_PICT_SKIN;
                end
                else if (cp == ecs_pkg::CP_ZWJ)
                begin
                    held_next = cp;
                    mode_next = MODE_PICT_ZWJ;
                end
                else
                begin
                    do_fresh = 1'b1;
                end
            end
            MODE_PICT_SKIN:
            begin
                if (cp == ecs_pkg::CP_ZWJ)
                begin
                    held_next = cp;
                    mode_next = MODE_PICT_ZWJ;
                end
                else
                begin
                    do_fresh = 1'b1;
                end
            end
            MODE_PICT_ZWJ:
            begin
                if (ecs_pkg::is_pict(cp))
                begin
                    push(slots, n, ecs_pkg::CP_ZWJ, ecs_pkg::KIND_PICT, 1'b0);
                    push(slots, n, cp, ecs_pkg::KIND_PICT, 1'b0);
                    mode_next = MODE_PICT_BASE;
                end
                else
                begin
                    push(slots, n, ecs_pkg::CP_ZWJ, ecs_pkg::KIND_PLAIN, 1'b1);
                    do_fresh = 1'b1;
                end
            end
            MODE_IDLE:
            begin
                do_fresh = 1'b1;
            end
        endcase

        // codepoint that was not absorbed by the open cluster starts over
        if (do_fresh)
        begin
            if (ecs_pkg::is_key_base(cp))
            begin
                held_next = cp;
                mode_next = MODE_KEY_BASE;
            end
            else if (ecs_pkg::is_ri(cp))
            begin
                held_next = cp;
                mode_next = MODE_RI;
            end
            else if (ecs_pkg::is_pict(cp))
            begin
                push(slots, n, cp, ecs_pkg::KIND_PICT, 1'b1);
                mode_next = MODE_PICT_BASE;
            end
            else
            begin
                push(slots, n, cp, ecs_pkg::KIND_PLAIN, 1'b1);
                mode_next = MODE_IDLE;
            end
        end

        // end of text flushes whatever is still held as plain
        if (item.end_of_text)
        begin
            case (mode_next) inside
                MODE_KEY_BASE, MODE_RI, MODE_PICT_ZWJ:
                begin
                    push(slots, n, held_next, ecs_pkg::KIND_PLAIN, 1'b1);
                end
                MODE_KEY_VS:
                begin
                    push(slots, n, held_next, ecs_pkg::KIND_PLAIN, 1'b1);
                    push(slots, n, ecs_pkg::CP_VS16, ecs_pkg::KIND_PLAIN, 1'b1);
                end
                default:
                begin
                end
            endcase
            mode_next = MODE_IDLE;
            held_next = ecs_pkg::CP_ZERO;
        end
    end

    assign res.slots = slots;
    assign res.count = n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            held_reg <= ecs_pkg::CP_ZERO;
        end
        else if (adv)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
        end
    end

`ifndef SYNTH
    a_eot_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (adv && item.end_of_text) |=> (mode_reg == MODE_IDLE))
        else $error("mode not idle after end of text");

    a_silent_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (adv && (res.count == '0)) |=>
        (mode_reg == MODE_KEY_BASE || mode_reg == MODE_KEY_VS ||
         mode_reg == MODE_RI || mode_reg == MODE_PICT_ZWJ))
        else $error("request with no result left no codepoint held");
`endif

endmodule

// ===== rtl/ecs_out_buf.sv =====
// result register: holds the results of one request and releases them one per cycle while ready is high
module ecs_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ecs_pkg::parse_res_t res,
    output logic                free,
    ecs_out_if.source           out_ch
);

    ecs_pkg::res_vec_t         slots_reg;
    logic [ecs_pkg::CNT_W-1:0] cnt_reg;
    logic [ecs_pkg::CNT_W-1:0] cnt_next;
    logic [ecs_pkg::IDX_W-1:0] idx_reg;
    logic [ecs_pkg::IDX_W-1:0] idx_next;
    logic                      pop;
    ecs_pkg::result_t          cur;

    assign cur                   = slots_reg[idx_reg];
    assign out_ch.valid          = (cnt_reg != '0);
    assign out_ch.out_codepoint  = cur.codepoint;
    assign out_ch.cluster_kind   = cur.kind;
    assign out_ch.starts_cluster = cur.start;
    assign out_ch.last           = (cnt_reg == ecs_pkg::CNT_W'(1));

    assign pop  = out_ch.valid && out_ch.ready;
    // room for a new set when empty or once the last pending result goes out this cycle
    assign free = (cnt_reg == '0) || ((cnt_reg == ecs_pkg::CNT_W'(1)) && out_ch.ready);

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = res.count;
            idx_next = '0;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - ecs_pkg::CNT_W'(1);
            idx_next = idx_reg + ecs_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slots_reg <= res.slots;
        end
    end

`ifndef SYNTH
    a_idx_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, cnt_reg} + {{(ecs_pkg::CNT_W - ecs_pkg::IDX_W + 1){1'b0}}, idx_reg})
            <= (ecs_pkg::CNT_W + 1)'(ecs_pkg::MAX_RESULTS))
        else $error("result index runs past the stored set");

    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ((cnt_reg == '0) || ((cnt_reg == ecs_pkg::CNT_W'(1)) && pop)))
        else $error("new result set loaded over undelivered results");
`endif

endmodule
